// File: hw/rtl/dsfe_pkg.sv
// shared types, codes and helper functions of the dle/stx frame encoder
// used by dsfe_front, dsfe_queue, dsfe_back and the top level
`default_nettype none

package dsfe_pkg;

	localparam int BYTE_W     = 8;
	localparam int BOARD_W    = 4;
	localparam int CRC_W      = 16;
	localparam int CFG_ADDR_W = 1;

	localparam logic [BYTE_W-1:0] DLE_CODE = 8'h10;
	localparam logic [BYTE_W-1:0] STX_CODE = 8'h02;
	localparam logic [BYTE_W-1:0] ETX_CODE = 8'h03;

	// crc-16/arc in reflected form
	localparam logic [CRC_W-1:0] CRC_POLY_REFL = 16'hA001;
	localparam logic [CRC_W-1:0] CRC_INIT      = 16'h0000;

	localparam logic [BOARD_W-1:0] DEST_BOARD_RST    = 4'd1;
	localparam logic [BYTE_W-1:0]  FRAME_COMMAND_RST = 8'd3;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_DEST_BOARD    = 1'b0,
		REG_FRAME_COMMAND = 1'b1
	} cfg_reg_t;

	// one classified word handed from front to back
	typedef struct packed {
		logic              open;
		logic [BYTE_W-1:0] mask;
		logic [BYTE_W-1:0] cmd;
		logic              has_data;
		logic [BYTE_W-1:0] data;
		logic              close;
	} job_t;

	// one-hot destination mask, zero for boards outside 1..8
	function automatic logic [BYTE_W-1:0] board_mask(input logic [BOARD_W-1:0] board);
		logic [BOARD_W-1:0] sh;
		sh = board - 4'd1;
		if (board >= 4'd1 && board <= 4'd8)
			return 8'b1 << sh[2:0];
		else
			return '0;
	endfunction

	// one byte through the reflected crc, lsb first
	function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY_REFL;
			else
				c = c >> 1;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dsfe_front.sv
// front end: config registers, frame-open tracking and word classification
// depends on dsfe_pkg
`default_nettype none

module dsfe_front (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [dsfe_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  wire logic [dsfe_pkg::BYTE_W-1:0]           cfg_wdata,
	input  wire logic                                  accept,
	input  wire logic [dsfe_pkg::BYTE_W-1:0]           payload_byte,
	input  wire logic                                  last_byte,
	input  wire logic                                  empty_frame,
	output dsfe_pkg::job_t                             job
);

	logic [dsfe_pkg::BOARD_W-1:0] dest_board_q;
	logic [dsfe_pkg::BYTE_W-1:0]  frame_command_q;
	logic                         in_frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_board_q    <= dsfe_pkg::DEST_BOARD_RST;
			frame_command_q <= dsfe_pkg::FRAME_COMMAND_RST;
		end else if (cfg_we) begin
			case (dsfe_pkg::cfg_reg_t'(cfg_addr))
				dsfe_pkg::REG_DEST_BOARD:    dest_board_q <= cfg_wdata[dsfe_pkg::BOARD_W-1:0];
				dsfe_pkg::REG_FRAME_COMMAND: frame_command_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// empty request wins over last
	always_comb begin
		job.open     = !in_frame_q;
		job.mask     = dsfe_pkg::board_mask(dest_board_q);
		job.cmd      = frame_command_q;
		job.has_data = !empty_frame;
		job.data     = payload_byte;
		job.close    = empty_frame | last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_frame_q <= 1'b0;
		else if (accept)
			in_frame_q <= !job.close;
	end

endmodule

`default_nettype wire

// File: hw/rtl/dsfe_queue.sv
// short job queue between front and back
// depends on dsfe_pkg
`default_nettype none

module dsfe_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire dsfe_pkg::job_t push_job,
	output logic          full,
	input  wire logic     pop,
	output dsfe_pkg::job_t head,
	output logic          head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	dsfe_pkg::job_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == DEPTH_CNT);
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/dsfe_back.sv
// back end: byte sequencer with stuffing, running crc and output register
// depends on dsfe_pkg
`default_nettype none

module dsfe_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dsfe_pkg::job_t               head,
	input  wire logic                         head_valid,
	output logic                              pop,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [dsfe_pkg::BYTE_W-1:0]       m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser
);

	typedef enum logic [3:0] {
		PH_DLE_O, PH_STX, PH_MASK, PH_CMD, PH_DATA, PH_CRCH, PH_CRCL, PH_DLE_C, PH_ETX
	} phase_t;

	phase_t                        phase_q;
	logic                          busy_q;
	logic                          dup_q;
	logic [dsfe_pkg::CRC_W-1:0]    crc_q;
	logic                          ovalid_q;
	logic [dsfe_pkg::BYTE_W-1:0]   obyte_q;
	logic                          orun_q;
	logic                          oeof_q;

	phase_t                        first_ph;
	phase_t                        cur_ph;
	phase_t                        next_ph;
	logic [dsfe_pkg::BYTE_W-1:0]   cur_byte;
	logic                          stuffable;
	logic                          ph_done;
	logic                          dup_now;
	logic                          fire;
	logic                          done;
	logic                          feed;

	always_comb begin
		if (head.open)
			first_ph = PH_DLE_O;
		else if (head.has_data)
			first_ph = PH_DATA;
		else
			first_ph = PH_CRCH;
		cur_ph = busy_q ? phase_q : first_ph;

		cur_byte  = dsfe_pkg::DLE_CODE;
		stuffable = 1'b0;
		ph_done   = 1'b0;
		next_ph   = cur_ph;
		feed      = 1'b0;
		case (cur_ph)
			PH_DLE_O: begin
				cur_byte = dsfe_pkg::DLE_CODE;
				next_ph  = PH_STX;
			end
			PH_STX: begin
				cur_byte = dsfe_pkg::STX_CODE;
				next_ph  = PH_MASK;
			end
			PH_MASK: begin
				cur_byte  = head.mask;
				stuffable = 1'b1;
				feed      = 1'b1;
				next_ph   = PH_CMD;
			end
			PH_CMD: begin
				cur_byte  = head.cmd;
				stuffable = 1'b1;
				feed      = 1'b1;
				next_ph   = head.has_data ? PH_DATA : PH_CRCH;
			end
			PH_DATA: begin
				cur_byte  = head.data;
				stuffable = 1'b1;
				feed      = 1'b1;
				next_ph   = PH_CRCH;
				ph_done   = !head.close;
			end
			PH_CRCH: begin
				cur_byte  = crc_q[15:8];
				stuffable = 1'b1;
				next_ph   = PH_CRCL;
			end
			PH_CRCL: begin
				cur_byte  = crc_q[7:0];
				stuffable = 1'b1;
				next_ph   = PH_DLE_C;
			end
			PH_DLE_C: begin
				cur_byte = dsfe_pkg::DLE_CODE;
				next_ph  = PH_ETX;
			end
			PH_ETX: begin
				cur_byte = dsfe_pkg::ETX_CODE;
				ph_done  = 1'b1;
			end
			default: ;
		endcase

		dup_now = stuffable && (cur_byte == dsfe_pkg::DLE_CODE) && !dup_q;
		fire    = head_valid && (!ovalid_q || m_tready);
		done    = fire && !dup_now && ph_done;
	end

	assign pop      = done;
	assign m_tvalid = ovalid_q;
	assign m_tdata  = obyte_q;
	assign m_tlast  = orun_q;
	assign m_tuser  = oeof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DLE_O;
			busy_q   <= 1'b0;
			dup_q    <= 1'b0;
			crc_q    <= dsfe_pkg::CRC_INIT;
			ovalid_q <= 1'b0;
			obyte_q  <= '0;
			orun_q   <= 1'b0;
			oeof_q   <= 1'b0;
		end else if (fire) begin
			ovalid_q <= 1'b1;
			obyte_q  <= cur_byte;
			orun_q   <= done;
			oeof_q   <= (cur_ph == PH_ETX);
			if (dup_now) begin
				phase_q <= cur_ph;
				busy_q  <= 1'b1;
				dup_q   <= 1'b1;
			end else if (ph_done) begin
				busy_q <= 1'b0;
				dup_q  <= 1'b0;
			end else begin
				phase_q <= next_ph;
				busy_q  <= 1'b1;
				dup_q   <= 1'b0;
			end
			// crc restarts at frame open, takes each mask, command and payload byte once
			if (cur_ph == PH_DLE_O)
				crc_q <= dsfe_pkg::CRC_INIT;
			else if (feed && !dup_q)
				crc_q <= dsfe_pkg::crc16_byte(crc_q, cur_byte);
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	a_eof_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && oeof_q |-> orun_q)
		else $error("frame end not marked as end of run");

	a_busy_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> head_valid)
		else $error("sequencer busy with no queued job");

	a_dup_repeats_dle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && dup_now |=> ovalid_q && (obyte_q == dsfe_pkg::DLE_CODE) && dup_q)
		else $error("stuffed byte not a repeated dle");

	a_stx_after_open: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (cur_ph == PH_DLE_O) |=> busy_q && (phase_q == PH_STX))
		else $error("frame open not followed by stx");

endmodule

`default_nettype wire

// File: hw/rtl/dle_stx_frame_encoder_crc16.sv
// top level of the dle/stx frame encoder with crc-16/arc trailer
// depends on dsfe_pkg, dsfe_front, dsfe_queue, dsfe_back
`default_nettype none

// Frame encoder: payload words come in on the s_ side, one byte each, and the
// stuffed line bytes leave on the m_ side, one byte per cycle while m_tready is
// high. The first word of a frame opens it with DLE STX, the one-hot destination
// mask and the command byte (both taken from the registers at that moment);
// every payload byte follows; a word with tlast, or an empty-frame word (tuser),
// closes the frame with the CRC-16/ARC over mask, command and payload (high byte
// first) and DLE ETX. Every 0x10 among mask, command, payload and crc bytes is
// doubled. The front classifies each word in the cycle it is taken and drops it
// in a QUEUE_DEPTH-entry job queue; the back sequencer drains that queue at one
// line byte per cycle while m_tready is high. A mid-frame word therefore yields
// one line byte, or two when its byte is 0x10; an opening word adds 4 to 6 bytes
// and a closing word 4 to 6, so one word yields 1 to 14 line bytes. s_tready is
// high whenever the queue has room, so short bursts are taken at one word per
// cycle while the back is still sending. m_tlast marks the last byte caused by
// a word, m_tuser the closing ETX. Config is written through
// cfg_we/cfg_addr/cfg_wdata: index 0 is the destination board (1..8, other
// values give a zero mask), index 1 the command byte.
module dle_stx_frame_encoder_crc16 #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic [dsfe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  wire logic [dsfe_pkg::BYTE_W-1:0]       cfg_wdata,
	// input word stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [dsfe_pkg::BYTE_W-1:0]       s_tdata,  // [7:0] payload_byte
	input  wire logic                              s_tlast,  // last_byte
	input  wire logic                              s_tuser,  // [0] empty_frame
	// line byte stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [dsfe_pkg::BYTE_W-1:0]            m_tdata,  // [7:0] out_byte
	output logic                                   m_tlast,  // end_of_run
	output logic                                   m_tuser   // [0] end_of_frame
);

	dsfe_pkg::job_t new_job;
	dsfe_pkg::job_t head_job;
	logic           queue_full;
	logic           head_valid;
	logic           pop;
	logic           accept;

	// a word is taken whenever the queue has a free slot
	assign s_tready = !queue_full;
	assign accept   = s_tvalid && s_tready;

	dsfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.payload_byte (s_tdata),
		.last_byte    (s_tlast),
		.empty_frame  (s_tuser),
		.job          (new_job)
	);

	dsfe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_job   (new_job),
		.full       (queue_full),
		.pop        (pop),
		.head       (head_job),
		.head_valid (head_valid)
	);

	dsfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.head_valid (head_valid),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

// File: dv/dle_stx_frame_encoder_crc16_checker.sv
`timescale 1ns / 1ps
// line byte predictor and scoreboard for the dle/stx frame encoder
// depends on dsfe_pkg; watches the config port and both word streams of the block

module dle_stx_frame_encoder_crc16_checker
	import dsfe_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [BYTE_W-1:0]     cfg_wdata,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,  // [7:0] payload_byte
	input  wire logic                  s_tlast,  // last_byte
	input  wire logic                  s_tuser,  // [0] empty_frame
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [BYTE_W-1:0]     m_tdata,  // [7:0] out_byte
	input  wire logic                  m_tlast,  // end_of_run
	input  wire logic                  m_tuser,  // [0] end_of_frame
	output int                         fail_count,
	output int                         bytes_pending,
	output int                         bytes_checked
);

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              run_end;
		logic              frame_end;
	} line_byte_t;

	line_byte_t line_due[$];

	logic [BOARD_W-1:0] board_sel   = DEST_BOARD_RST;
	logic [BYTE_W-1:0]  command_sel = FRAME_COMMAND_RST;
	logic               frame_open  = 1'b0;
	logic [CRC_W-1:0]   crc_run     = CRC_INIT;
	int                 errs        = 0;
	int                 checked     = 0;

	// reflected crc-16/arc, one message bit at a time, lsb first
	function automatic logic [CRC_W-1:0] crc_arc_next(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc;
		for (int k = 0; k < BYTE_W; k++) begin
			if (c[0] ^ b[k])
				c = (c >> 1) ^ CRC_POLY_REFL;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	task automatic emit(input logic [BYTE_W-1:0] b, input logic frame_end);
		line_byte_t e;
		e.value     = b;
		e.run_end   = 1'b0;
		e.frame_end = frame_end;
		line_due    = {line_due, e};
	endtask

	// dle inside the frame body goes out twice
	task automatic emit_stuffed(input logic [BYTE_W-1:0] b);
		emit(b, 1'b0);
		if (b == DLE_CODE)
			emit(b, 1'b0);
	endtask

	task automatic encode_word(input logic [BYTE_W-1:0] data, input logic last,
		input logic empty);
		logic [BYTE_W-1:0] mask;
		logic              close;
		line_byte_t        tail;
		int                n;
		if (!frame_open) begin
			// mask and command are latched from the registers at open
			mask = (board_sel >= 4'd1 && board_sel <= 4'd8) ?
				(8'h01 << (board_sel - 4'd1)) : 8'h00;
			emit(DLE_CODE, 1'b0);
			emit(STX_CODE, 1'b0);
			crc_run = crc_arc_next(crc_arc_next(CRC_INIT, mask), command_sel);
			emit_stuffed(mask);
			emit_stuffed(command_sel);
			frame_open = 1'b1;
		end
		if (empty)
			close = 1'b1;
		else begin
			crc_run = crc_arc_next(crc_run, data);
			emit_stuffed(data);
			close = last;
		end
		if (close) begin
			emit_stuffed(crc_run[15:8]);
			emit_stuffed(crc_run[7:0]);
			emit(DLE_CODE, 1'b0);
			emit(ETX_CODE, 1'b1);
			frame_open = 1'b0;
			crc_run    = CRC_INIT;
		end
		n            = line_due.size() - 1;
		tail         = line_due[n];
		tail.run_end = 1'b1;
		line_due[n]  = tail;
	endtask

	task automatic check_line_byte();
		line_byte_t e;
		if (line_due.size() == 0) begin
			$error("line byte %02h arrived with no word pending to cause it", m_tdata);
			errs++;
		end else begin
			e = line_due.pop_front();
			if (m_tdata !== e.value) begin
				$error("out_byte: expected %02h, got %02h", e.value, m_tdata);
				errs++;
			end
			if (m_tlast !== e.run_end) begin
				$error("end_of_run: expected %0b, got %0b", e.run_end, m_tlast);
				errs++;
			end
			if (m_tuser !== e.frame_end) begin
				$error("end_of_frame: expected %0b, got %0b", e.frame_end, m_tuser);
				errs++;
			end
		end
		checked++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			line_due.delete();
			board_sel   = DEST_BOARD_RST;
			command_sel = FRAME_COMMAND_RST;
			frame_open  = 1'b0;
			crc_run     = CRC_INIT;
		end else begin
			if (cfg_we) begin
				if (cfg_addr == REG_DEST_BOARD)
					board_sel = cfg_wdata[BOARD_W-1:0];
				else if (cfg_addr == REG_FRAME_COMMAND)
					command_sel = cfg_wdata;
			end
			if (s_tvalid && s_tready)
				encode_word(s_tdata, s_tlast, s_tuser);
			if (m_tvalid && m_tready)
				check_line_byte();
		end
		bytes_pending <= line_due.size();
		fail_count    <= errs;
		bytes_checked <= checked;
	end

endmodule

// File: dv/dle_stx_frame_encoder_crc16_test.sv
`timescale 1ns / 1ps
// testbench top for the dle/stx frame encoder with crc-16/arc trailer
// depends on dsfe_pkg, the encoder rtl and dle_stx_frame_encoder_crc16_checker

module dle_stx_frame_encoder_crc16_test;
	import dsfe_pkg::*;

	localparam int RAND_PHASES  = 6;
	localparam int PHASE_WORDS  = 40;
	localparam int DRAIN_CYCLES = 16;    // a word yields at most 14 line bytes
	localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on either side

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = REG_DEST_BOARD;
	logic [BYTE_W-1:0]     cfg_wdata = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [BYTE_W-1:0]     s_tdata   = '0;
	logic                  s_tlast   = 1'b0;
	logic                  s_tuser   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [BYTE_W-1:0]     m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	int fail_count;
	int bytes_pending;
	int bytes_checked;

	// no_idle turns off the random gaps on both sides for a whole phase
	logic no_idle     = 1'b0;
	int   sink_hold   = 0;
	int   dead_cycles = 0;
	int   words_sent  = 0;
	int   cfg_writes  = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	dle_stx_frame_encoder_crc16 u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	dle_stx_frame_encoder_crc16_checker u_frame_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.bytes_pending(bytes_pending),
		.bytes_checked(bytes_checked)
	);

	// line side: after each taken byte may hold tready low for a random gap, none when no_idle is set
	always @(posedge clk) begin : line_sink
		int hold;
		if (arst_n) begin
			if (sink_hold != 0) begin
				sink_hold <= sink_hold - 1;
				m_tready  <= (sink_hold == 1);
			end else if (m_tvalid && m_tready) begin
				hold = no_idle ? 0 : $urandom_range(0, 5);
				sink_hold <= hold;
				m_tready  <= (hold == 0);
			end else
				m_tready <= 1'b1;
		end
	end

	// watchdog: nothing moved for too long means the block is stuck
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			dead_cycles <= 0;
		else if (dead_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d line bytes still due",
				STALL_LIMIT, bytes_pending);
			$display("*** FAILED ***");
			$finish;
		end else
			dead_cycles <= dead_cycles + 1;
	end

	// one input word; tvalid stays high into the next word when there is no gap
	task automatic send_word(input logic [BYTE_W-1:0] data, input logic last,
		input logic empty);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= last;
		s_tuser  <= empty;
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
	endtask

	// stop sending and wait until every predicted line byte has come out;
	// a clock edge is awaited first so the count includes the word just taken
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [BYTE_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	initial begin : stimulus
		int                directed_words;
		int                phase_words;
		int                len;
		logic [BYTE_W-1:0] data;
		logic [BYTE_W-1:0] board_word;
		logic [BYTE_W-1:0] cmd_word;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: board 1, command 3
		send_word(8'h00, 1'b1, 1'b0);       // one-byte frame
		send_word(8'hA5, 1'b0, 1'b1);       // empty frame, payload ignored
		send_word(DLE_CODE, 1'b0, 1'b0);    // payload dle gets doubled
		send_word(8'hFF, 1'b0, 1'b0);
		send_word(8'h55, 1'b0, 1'b0);
		send_word(8'h3C, 1'b0, 1'b1);       // empty request closes the open frame
		send_word(8'hAA, 1'b1, 1'b1);       // empty wins over last
		drain();

		// top board, command byte that needs stuffing
		write_reg(REG_DEST_BOARD, 8'h08);
		write_reg(REG_FRAME_COMMAND, DLE_CODE);
		send_word(DLE_CODE, 1'b1, 1'b0);
		drain();

		// board 5 gives a dle mask; registers change while the frame is open
		write_reg(REG_DEST_BOARD, 8'h05);
		write_reg(REG_FRAME_COMMAND, 8'hFF);
		send_word(8'h00, 1'b0, 1'b0);
		drain();
		write_reg(REG_DEST_BOARD, 8'h00);
		write_reg(REG_FRAME_COMMAND, 8'h00);
		send_word(8'h7F, 1'b1, 1'b0);       // still closes with board 5 header crc
		send_word(8'h00, 1'b0, 1'b1);       // board 0 gives a zero mask
		drain();

		// boards past 8, with the upper data bits of the write set
		write_reg(REG_DEST_BOARD, 8'hF9);
		send_word(8'h01, 1'b1, 1'b0);
		drain();
		write_reg(REG_DEST_BOARD, 8'hFF);
		send_word(8'hC3, 1'b0, 1'b1);
		drain();

		// crc bytes equal to dle: empty frame gives 0x1080, payload 0x80 gives 0x0010
		write_reg(REG_DEST_BOARD, 8'h01);
		write_reg(REG_FRAME_COMMAND, 8'hFE);
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'h80, 1'b1, 1'b0);
		drain();
		directed_words = words_sent;

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			// the phase before may have left a frame open; its header is already latched
			board_word = BYTE_W'($urandom_range(0, 255));
			if ($urandom_range(0, 2) == 0)
				board_word[BOARD_W-1:0] = $urandom_range(0, 1) ? 4'd1 : 4'd8;
			case ($urandom_range(0, 3))
				0:       cmd_word = 8'h00;
				1:       cmd_word = 8'hFF;
				2:       cmd_word = DLE_CODE;
				default: cmd_word = BYTE_W'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 2))
				0: write_reg(REG_DEST_BOARD, board_word);
				1: write_reg(REG_FRAME_COMMAND, cmd_word);
				default: begin
					write_reg(REG_DEST_BOARD, board_word);
					write_reg(REG_FRAME_COMMAND, cmd_word);
				end
			endcase
			no_idle = ($urandom_range(0, 3) == 0);

			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				case ($urandom_range(0, 11))
					0: begin
						// lone empty request, last bit random
						send_word(BYTE_W'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'b1);
						phase_words++;
					end
					1: begin
						// noise word with random flags
						send_word(BYTE_W'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
						phase_words++;
					end
					default: begin
						// well-formed frame, mostly short, dle-heavy payload
						len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) :
							$urandom_range(1, 8);
						for (int i = 0; i < len; i++) begin
							data = ($urandom_range(0, 5) == 0) ? DLE_CODE :
								BYTE_W'($urandom_range(0, 255));
							if (i < len - 1)
								send_word(data, 1'b0, 1'b0);
							else if ($urandom_range(0, 4) == 0) begin
								// close with a separate empty request instead of tlast
								send_word(data, 1'b0, 1'b0);
								send_word(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b1);
								phase_words++;
							end else
								send_word(data, 1'b1, 1'b0);
							phase_words++;
						end
					end
				endcase
			end
			drain();
		end

		$display("run covered %0d input words (%0d directed) over %0d config writes",
			words_sent, directed_words, cfg_writes);
		$display("%0d line bytes compared, %0d mismatches", bytes_checked, fail_count);
		if (fail_count == 0 && bytes_pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
